// ===== rtl/core/ipav_pkg.sv =====
// Shared types and helpers for the IP address text validator.
// Used by the check modules and the top level; depends on nothing.
`default_nettype none

package ipav_pkg;

	localparam logic [7:0] CHAR_END   = 8'h00;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;

	localparam logic [1:0]  V6_MIN_COLONS = 2'd2;
	localparam logic [1:0]  V6_MAX_RUN    = 2'd2;
	localparam logic [1:0]  V6_RUN_SAT    = 2'd3;
	localparam logic [2:0]  V6_GROUP_MAX  = 3'd4;
	localparam logic [2:0]  V6_GROUP_SAT  = 3'd5;
	localparam logic [2:0]  V4_DOTS       = 3'd3;
	localparam logic [2:0]  V4_DOT_SAT    = 3'd4;
	localparam logic [2:0]  V4_DIGITS_MAX = 3'd3;
	localparam logic [2:0]  V4_DIGIT_SAT  = 3'd4;
	localparam logic [11:0] V4_OCTET_MAX  = 12'd255;

	typedef struct packed {
		logic       is_colon;
		logic       is_dot;
		logic       is_dec;
		logic       is_hex;
		logic [3:0] digit;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		r.is_colon = (c == CHAR_COLON);
		r.is_dot   = (c == CHAR_DOT);
		r.is_dec   = (c >= 8'h30) && (c <= 8'h39);
		r.is_hex   = r.is_dec || ((c >= 8'h61) && (c <= 8'h66)) ||
		             ((c >= 8'h41) && (c <= 8'h46));
		r.digit    = c[3:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ipav_char_if.sv =====
// Valid/ready channel that carries one character of the string.
// No dependencies.
`default_nettype none

interface ipav_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ipav_verdict_if.sv =====
// Valid/ready channel that carries one verdict per string.
// No dependencies.
`default_nettype none

interface ipav_verdict_if;
	logic valid;
	logic ready;
	logic is_address;
	logic judged_ipv6;

	modport source (output valid, output is_address, output judged_ipv6, input ready);
	modport sink (input valid, input is_address, input judged_ipv6, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ipav_v6_check.sv =====
// IPv6 rule tracking: colon counts, colon runs and hex group length.
// Depends on ipav_pkg.
`default_nettype none

module ipav_v6_check (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wire                  clear,
	input  ipav_pkg::char_class_t cls,
	output logic                 ok
);
	import ipav_pkg::*;

	logic       failed_q;
	logic [1:0] colon_total_q;
	logic [1:0] colon_run_q;
	logic [1:0] longest_run_q;
	logic [2:0] group_len_q;

	logic [1:0] run_next;
	logic [2:0] group_next;

	always_comb begin
		run_next   = (colon_run_q < V6_RUN_SAT) ? colon_run_q + 2'd1 : colon_run_q;
		group_next = (group_len_q < V6_GROUP_SAT) ? group_len_q + 3'd1 : group_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q      <= 1'b0;
			colon_total_q <= '0;
			colon_run_q   <= '0;
			longest_run_q <= '0;
			group_len_q   <= '0;
		end else if (step && clear) begin
			failed_q      <= 1'b0;
			colon_total_q <= '0;
			colon_run_q   <= '0;
			longest_run_q <= '0;
			group_len_q   <= '0;
		end else if (step) begin
			if (cls.is_colon) begin
				if (colon_total_q < V6_RUN_SAT) begin
					colon_total_q <= colon_total_q + 2'd1;
				end
				colon_run_q <= run_next;
				if (run_next > longest_run_q) begin
					longest_run_q <= run_next;
				end
				group_len_q <= '0;
			end else begin
				colon_run_q <= '0;
				if (!cls.is_hex) begin
					failed_q <= 1'b1;
				end else begin
					group_len_q <= group_next;
					if (group_next > V6_GROUP_MAX) begin
						failed_q <= 1'b1;
					end
				end
			end
		end
	end

	assign ok = !failed_q && (colon_total_q >= V6_MIN_COLONS) && (longest_run_q <= V6_MAX_RUN);

endmodule

`default_nettype wire

// ===== rtl/core/ipav_v4_check.sv =====
// IPv4 rule tracking: dot count, octet digits, octet value, leading zero.
// Depends on ipav_pkg.
`default_nettype none

module ipav_v4_check (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wire                  clear,
	input  ipav_pkg::char_class_t cls,
	output logic                 ok
);
	import ipav_pkg::*;

	logic        failed_q;
	logic [11:0] octet_q;
	logic [2:0]  dot_total_q;
	logic [2:0]  digit_total_q;
	logic        lead_zero_q;

	logic [11:0] octet_next;
	logic [2:0]  digits_next;
	logic        lead_next;

	// Multiply by ten as two shifts; the octet never exceeds 999, so 12 bits hold it.
	always_comb begin
		octet_next  = (digit_total_q < V4_DIGITS_MAX) ?
		              (octet_q << 3) + (octet_q << 1) + {8'd0, cls.digit} : octet_q;
		digits_next = (digit_total_q < V4_DIGIT_SAT) ? digit_total_q + 3'd1 : digit_total_q;
		lead_next   = (digit_total_q == 3'd0) ? (cls.digit == 4'd0) : lead_zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q      <= 1'b0;
			octet_q       <= '0;
			dot_total_q   <= '0;
			digit_total_q <= '0;
			lead_zero_q   <= 1'b0;
		end else if (step && clear) begin
			failed_q      <= 1'b0;
			octet_q       <= '0;
			dot_total_q   <= '0;
			digit_total_q <= '0;
			lead_zero_q   <= 1'b0;
		end else if (step) begin
			if (cls.is_dot) begin
				if (digit_total_q == 3'd0) begin
					failed_q <= 1'b1;
				end
				if (dot_total_q < V4_DOT_SAT) begin
					dot_total_q <= dot_total_q + 3'd1;
				end
				octet_q       <= '0;
				digit_total_q <= '0;
				lead_zero_q   <= 1'b0;
			end else if (!cls.is_dec) begin
				failed_q <= 1'b1;
			end else begin
				octet_q       <= octet_next;
				digit_total_q <= digits_next;
				lead_zero_q   <= lead_next;
				if ((digits_next > V4_DIGITS_MAX) || (octet_next > V4_OCTET_MAX) ||
				    ((digits_next > 3'd1) && lead_next)) begin
					failed_q <= 1'b1;
				end
			end
		end
	end

	assign ok = !failed_q && (digit_total_q != 3'd0) && (dot_total_q == V4_DOTS);

endmodule

`default_nettype wire

// ===== rtl/core/ip_address_text_validator_core.sv =====
// Checks a character stream one byte per cycle and reports whether each string
// is a well-formed IPv4 or IPv6 address. A byte is taken every cycle while the
// verdict channel keeps up; each byte is held in an input register while the
// IPv4 and IPv6 rule trackers update in parallel, and the end byte (code 0)
// loads the verdict register, so a verdict passes the input register and then
// the verdict register after its end byte is accepted. Throughput is one byte
// per cycle; it stalls only while a verdict waits and a second end byte is
// ready to leave the input register.
// Depends on ipav_pkg, ipav_char_if, ipav_verdict_if, ipav_v6_check, ipav_v4_check.
`default_nettype none

module ip_address_text_validator_core (
	input  wire             clk,
	input  wire             arst_n,
	ipav_char_if.sink       chars,
	ipav_verdict_if.source  verdicts
);
	import ipav_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        any_seen_q;
	logic        colon_seen_q;
	logic        out_valid_q;
	logic        out_addr_q;
	logic        out_v6_q;

	char_class_t cls;
	logic        term;
	logic        advance;
	logic        load_out;
	logic        v6_ok;
	logic        v4_ok;
	logic        verdict;

	assign cls      = classify(char_s1);
	assign term     = (char_s1 == CHAR_END);
	// A plain character never needs the output; an end byte needs a free slot.
	assign advance  = valid_s1 && (!term || !out_valid_q || verdicts.ready);
	assign load_out = advance && term;
	assign chars.ready = !valid_s1 || advance;

	ipav_v6_check u_v6 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.clear  (term),
		.cls    (cls),
		.ok     (v6_ok)
	);

	ipav_v4_check u_v4 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.clear  (term),
		.cls    (cls),
		.ok     (v4_ok)
	);

	assign verdict = any_seen_q && (colon_seen_q ? v6_ok : v4_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_seen_q   <= 1'b0;
			colon_seen_q <= 1'b0;
		end else if (advance) begin
			if (term) begin
				any_seen_q   <= 1'b0;
				colon_seen_q <= 1'b0;
			end else begin
				any_seen_q <= 1'b1;
				if (cls.is_colon) begin
					colon_seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_addr_q <= verdict;
			out_v6_q   <= colon_seen_q;
		end
	end

	assign verdicts.valid       = out_valid_q;
	assign verdicts.is_address  = out_addr_q;
	assign verdicts.judged_ipv6 = out_v6_q;

	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready && valid_s1) |-> advance)
		else $error("input register overwritten before its byte was used");

	a_load_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || verdicts.ready))
		else $error("verdict loaded over one not yet taken");

	a_verdict_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(load_out))
		else $error("verdict appeared without an end byte");

endmodule

`default_nettype wire
